### hw/rtl/utd_pkg.sv
`timescale 1ns / 1ps

package utd_pkg;

  localparam int COORD_WIDTH_DEF = 12;
  localparam int LW_WIDTH        = 13;

  localparam logic [LW_WIDTH-1:0] LINE_WIDTH_RST = 13'd640;

  localparam logic [4:0] LINE_STEP = 5'd20;
  localparam logic [4:0] ADV_ASCII = 5'd8;
  localparam logic [4:0] ADV_WIDE  = 5'd16;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_NL  = 8'h0a;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TEXT  = 1'b1;

  localparam logic [1:0] DUE_NONE = 2'd0;
  localparam logic [1:0] DUE_ONE  = 2'd1;
  localparam logic [1:0] DUE_TWO  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic [11:0] start_x;
    logic [11:0] start_y;
  } in_t;

  typedef struct packed {
    logic [15:0] code_point;
    logic [11:0] glyph_x;
    logic [11:0] glyph_y;
    logic [23:0] pixel_offset;
    logic [4:0]  glyph_width;
  } out_t;

endpackage

### hw/rtl/utf8_text_cursor_decoder.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// in       request    in_valid/in_stall   utd_pkg::in_t  (start or one UTF-8 byte)
// out      result     out_valid/out_stall utd_pkg::out_t (one glyph)
// cfg      write      cfg_we              line_width, 13 bits
//
// One byte per cycle while in_stall is low. Cursor and decode state update in the accept cycle;
// the glyph lands in a stage register, then the y*line_width+x multiply
// fills the output register.
// Synchronous active-low reset clears cursor, decode state and valids.
// in_stall rises only when both stages hold results and out_stall is high.

module utf8_text_cursor_decoder #(
  parameter int COORD_WIDTH = utd_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  utd_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output utd_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [utd_pkg::LW_WIDTH-1:0]     cfg_wdata
);

  localparam int          EW    = 17;
  localparam logic [EW-1:0] CMAX = EW'((1 << COORD_WIDTH) - 1);
  localparam int          PW    = COORD_WIDTH + utd_pkg::LW_WIDTH;

  logic [utd_pkg::LW_WIDTH-1:0] lw_r;
  logic [COORD_WIDTH-1:0]       cur_x_r, cur_x_nxt;
  logic [COORD_WIDTH-1:0]       cur_y_r, cur_y_nxt;
  logic [COORD_WIDTH-1:0]       line_x_r, line_x_nxt;
  logic [15:0]                  partial_r, partial_nxt;
  logic [1:0]                   due_r, due_nxt;

  logic                         s1_valid_r, s1_valid_nxt;
  logic [15:0]                  s1_cp_r;
  logic [COORD_WIDTH-1:0]       s1_x_r;
  logic [COORD_WIDTH-1:0]       s1_y_r;
  logic [4:0]                   s1_adv_r;

  logic                         out_valid_r, out_valid_nxt;
  utd_pkg::out_t                out_r;

  logic                         out_adv, s1_free, accept;
  logic                         emit;
  logic [15:0]                  emit_cp;
  logic [4:0]                   emit_adv;
  logic [15:0]                  merged;
  logic [EW-1:0]                sx_ext, sy_ext, xsum, ysum;
  logic [PW-1:0]                prod;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || out_adv;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  assign sx_ext = EW'(in_data.start_x);
  assign sy_ext = EW'(in_data.start_y);
  assign ysum   = EW'(cur_y_r) + EW'(utd_pkg::LINE_STEP);
  assign xsum   = EW'(cur_x_r) + EW'(emit_adv);

  always_comb begin
    case (due_r)
      utd_pkg::DUE_TWO: merged = partial_r | {4'h0, in_data.data_byte[5:0], 6'h00};
      default:          merged = partial_r | {10'h000, in_data.data_byte[5:0]};
    endcase
  end

  always_comb begin
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    line_x_nxt  = line_x_r;
    partial_nxt = partial_r;
    due_nxt     = due_r;
    emit        = 1'b0;
    emit_cp     = {8'h00, in_data.data_byte};
    emit_adv    = utd_pkg::ADV_ASCII;
    if (accept) begin
      if (in_data.func == utd_pkg::FUNC_START) begin
        cur_x_nxt   = (sx_ext > CMAX) ? CMAX[COORD_WIDTH-1:0] : sx_ext[COORD_WIDTH-1:0];
        line_x_nxt  = cur_x_nxt;
        cur_y_nxt   = (sy_ext > CMAX) ? CMAX[COORD_WIDTH-1:0] : sy_ext[COORD_WIDTH-1:0];
        partial_nxt = 16'h0000;
        due_nxt     = utd_pkg::DUE_NONE;
      end else if (in_data.data_byte == utd_pkg::CHAR_NUL) begin
        partial_nxt = 16'h0000;
        due_nxt     = utd_pkg::DUE_NONE;
      end else if (due_r != utd_pkg::DUE_NONE) begin
        due_nxt = due_r - 2'd1;
        if (due_r == utd_pkg::DUE_ONE) begin
          partial_nxt = 16'h0000;
          emit        = 1'b1;
          emit_cp     = merged;
          emit_adv    = utd_pkg::ADV_WIDE;
        end else begin
          partial_nxt = merged;
        end
      end else if (!in_data.data_byte[7]) begin
        if (in_data.data_byte == utd_pkg::CHAR_NL) begin
          cur_x_nxt = line_x_r;
          cur_y_nxt = (ysum > CMAX) ? CMAX[COORD_WIDTH-1:0] : ysum[COORD_WIDTH-1:0];
        end else begin
          emit = 1'b1;
        end
      end else if (in_data.data_byte[7:5] == 3'b110) begin
        partial_nxt = {5'h00, in_data.data_byte[4:0], 6'h00};
        due_nxt     = utd_pkg::DUE_ONE;
      end else if (in_data.data_byte[7:4] == 4'b1110) begin
        partial_nxt = {in_data.data_byte[3:0], 12'h000};
        due_nxt     = utd_pkg::DUE_TWO;
      end
      if (emit) begin
        cur_x_nxt = (xsum > CMAX) ? CMAX[COORD_WIDTH-1:0] : xsum[COORD_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_free ? (accept && emit) : s1_valid_r;
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  assign prod = PW'(s1_y_r) * PW'(lw_r) + PW'(s1_x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r        <= utd_pkg::LINE_WIDTH_RST;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      line_x_r    <= '0;
      partial_r   <= '0;
      due_r       <= utd_pkg::DUE_NONE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        lw_r <= cfg_wdata;
      end
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      line_x_r    <= line_x_nxt;
      partial_r   <= partial_nxt;
      due_r       <= due_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_cp_r  <= emit_cp;
      s1_x_r   <= cur_x_r;
      s1_y_r   <= cur_y_r;
      s1_adv_r <= emit_adv;
    end
    if (out_adv) begin
      out_r.code_point   <= s1_cp_r;
      out_r.glyph_x      <= 12'(s1_x_r);
      out_r.glyph_y      <= 12'(s1_y_r);
      out_r.pixel_offset <= 24'(prod);
      out_r.glyph_width  <= s1_adv_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks

  a_due_range: assert property (@(posedge clk) disable iff (!rst_n)
    due_r != 2'd3)
    else $error("decode count out of range");

  a_partial_idle: assert property (@(posedge clk) disable iff (!rst_n)
    due_r == utd_pkg::DUE_NONE |-> partial_r == 16'h0000)
    else $error("partial code held with no sequence open");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("request stalled with room in the pipe");

  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.glyph_width == utd_pkg::ADV_ASCII ||
                     out_r.glyph_width == utd_pkg::ADV_WIDE))
    else $error("bad glyph width");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  utd_pkg::in_t                 in_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  utd_pkg::out_t                out_data;
  logic                         cfg_we = 1'b0;
  logic [utd_pkg::LW_WIDTH-1:0] cfg_wdata = '0;

  utf8_text_cursor_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // cursor and decode state mirrored from the requests accepted so far
  logic [11:0]                  cur_x = '0;
  logic [11:0]                  cur_y = '0;
  logic [11:0]                  line_x = '0;
  logic [15:0]                  partial_cp = '0;
  logic [1:0]                   seq_due = utd_pkg::DUE_NONE;
  logic [utd_pkg::LW_WIDTH-1:0] line_width = utd_pkg::LINE_WIDTH_RST;

  utd_pkg::out_t glyphs_due[$];
  int            error_count = 0;
  int            cycles = 0;
  int            requests_sent = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [11:0] sat_step(logic [11:0] a, logic [4:0] d);
    logic [12:0] s;
    s = {1'b0, a} + 13'(d);
    return s[12] ? 12'hfff : s[11:0];
  endfunction

  function automatic utd_pkg::out_t place_glyph(logic [15:0] cp, logic [4:0] adv);
    utd_pkg::out_t g;
    int unsigned   off;
    off = 32'(cur_y) * 32'(line_width) + 32'(cur_x);
    g.code_point   = cp;
    g.glyph_x      = cur_x;
    g.glyph_y      = cur_y;
    g.pixel_offset = off[23:0];
    g.glyph_width  = adv;
    cur_x = sat_step(cur_x, adv);
    return g;
  endfunction

  function automatic bit decode_request(utd_pkg::in_t req, output utd_pkg::out_t g);
    logic [7:0] b;
    b = req.data_byte;
    g = '0;
    if (req.func == utd_pkg::FUNC_START) begin
      cur_x      = req.start_x;
      line_x     = req.start_x;
      cur_y      = req.start_y;
      partial_cp = '0;
      seq_due    = utd_pkg::DUE_NONE;
      return 1'b0;
    end
    if (b == utd_pkg::CHAR_NUL) begin
      partial_cp = '0;
      seq_due    = utd_pkg::DUE_NONE;
      return 1'b0;
    end
    if (seq_due != utd_pkg::DUE_NONE) begin
      partial_cp |= (seq_due == utd_pkg::DUE_TWO) ? {4'b0, b[5:0], 6'b0}
                                                  : {10'b0, b[5:0]};
      seq_due = seq_due - 2'd1;
      if (seq_due == utd_pkg::DUE_NONE) begin
        g = place_glyph(partial_cp, utd_pkg::ADV_WIDE);
        partial_cp = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    if (!b[7]) begin
      if (b == utd_pkg::CHAR_NL) begin
        cur_x = line_x;
        cur_y = sat_step(cur_y, utd_pkg::LINE_STEP);
        return 1'b0;
      end
      g = place_glyph({8'b0, b}, utd_pkg::ADV_ASCII);
      return 1'b1;
    end
    if (b[7:5] == 3'b110) begin
      partial_cp = {5'b0, b[4:0], 6'b0};
      seq_due    = utd_pkg::DUE_ONE;
    end else if (b[7:4] == 4'he) begin
      partial_cp = {b[3:0], 12'b0};
      seq_due    = utd_pkg::DUE_TWO;
    end
    return 1'b0;
  endfunction

  task automatic report(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    utd_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (glyphs_due.size() == 0) begin
        $display("%0t: unexpected glyph, expected none, actual %h", $time, out_data);
        error_count++;
      end else begin
        want = glyphs_due.pop_front();
        if (out_data.code_point !== want.code_point)
          report("code_point", want.code_point, out_data.code_point);
        if (out_data.glyph_x !== want.glyph_x)
          report("glyph_x", want.glyph_x, out_data.glyph_x);
        if (out_data.glyph_y !== want.glyph_y)
          report("glyph_y", want.glyph_y, out_data.glyph_y);
        if (out_data.pixel_offset !== want.pixel_offset)
          report("pixel_offset", want.pixel_offset, out_data.pixel_offset);
        if (out_data.glyph_width !== want.glyph_width)
          report("glyph_width", want.glyph_width, out_data.glyph_width);
      end
    end
  end

  task automatic send_request(utd_pkg::in_t req);
    utd_pkg::out_t g;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    if (decode_request(req, g))
      glyphs_due.push_back(g);
    requests_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    utd_pkg::in_t req;
    req.func      = utd_pkg::FUNC_TEXT;
    req.data_byte = b;
    req.start_x   = 12'($urandom);
    req.start_y   = 12'($urandom);
    send_request(req);
  endtask

  task automatic send_start(logic [11:0] x, logic [11:0] y);
    utd_pkg::in_t req;
    req.func      = utd_pkg::FUNC_START;
    req.data_byte = 8'($urandom);
    req.start_x   = x;
    req.start_y   = y;
    send_request(req);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (glyphs_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_line_width(logic [utd_pkg::LW_WIDTH-1:0] w);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we     <= 1'b0;
    line_width = w;
  endtask

  task automatic test_ascii_after_reset();
    send_byte(8'h41);
    send_byte(8'h7f);
    send_byte(8'h01);
    send_byte(utd_pkg::CHAR_NL);
    send_byte(8'h20);
    wait_drained();
  endtask

  task automatic test_cursor_saturation();
    send_start(12'hfff, 12'hff8);
    send_byte(8'h5a);
    send_byte(8'h5a);
    send_byte(utd_pkg::CHAR_NL);
    send_byte(8'h7a);
    wait_drained();
  endtask

  task automatic test_multibyte();
    send_start(12'd16, 12'd40);
    send_byte(8'hc2); send_byte(8'h80);
    send_byte(8'hdf); send_byte(8'hbf);
    send_byte(8'he2); send_byte(8'h82); send_byte(8'hac);
    send_byte(8'hef); send_byte(8'hbf); send_byte(8'hbf);
    // continuation bits are not checked, so a newline here is data
    send_byte(8'hc3); send_byte(utd_pkg::CHAR_NL);
    wait_drained();
  endtask

  task automatic test_skipped_bytes();
    send_byte(8'h80); send_byte(8'hbf); send_byte(8'hf0); send_byte(8'hff);
    send_byte(8'he2); send_byte(utd_pkg::CHAR_NUL); send_byte(8'h61);
    send_byte(8'hc5); send_start(12'd3, 12'd5); send_byte(8'h62);
    send_byte(utd_pkg::CHAR_NUL);
    wait_drained();
  endtask

  task automatic test_line_width_extremes();
    write_line_width('0);
    send_start(12'd100, 12'd300);
    send_byte(8'h41);
    wait_drained();
    write_line_width(13'h1fff);
    send_start(12'hfff, 12'hfff);
    send_byte(8'he4); send_byte(8'hb8); send_byte(8'ha5);
    wait_drained();
    write_line_width(13'd1);
    send_byte(8'h42);
    wait_drained();
    write_line_width(13'd4096);
    send_start(12'd7, 12'd4000);
    send_byte(8'h43);
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_start(12'd0, 12'd0);
    hold_cycles = 80;
    repeat (30) send_byte(8'($urandom_range(8'h21, 8'h7e)));
    wait_drained();
  endtask

  function automatic logic [11:0] rand_coord();
    return ($urandom_range(3) == 0) ? 12'($urandom_range(4000, 4095)) : 12'($urandom);
  endfunction

  task automatic send_random_text(int n);
    int stop_at;
    int pick;
    stop_at = requests_sent + n;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_start(rand_coord(), rand_coord());
      end else if (pick < 40) begin
        send_byte(8'($urandom_range(1, 127)));
      end else if (pick < 48) begin
        send_byte(utd_pkg::CHAR_NL);
      end else if (pick < 66) begin
        send_byte({3'b110, 5'($urandom)});
        send_byte({2'b10, 6'($urandom)});
      end else if (pick < 82) begin
        send_byte({4'he, 4'($urandom)});
        send_byte({2'b10, 6'($urandom)});
        send_byte({2'b10, 6'($urandom)});
      end else if (pick < 87) begin
        send_byte({4'he, 4'($urandom)});
        if ($urandom_range(1)) send_byte({2'b10, 6'($urandom)});
        if ($urandom_range(1)) send_byte(utd_pkg::CHAR_NUL);
        else send_start(rand_coord(), rand_coord());
      end else if (pick < 92) begin
        send_byte({3'b110, 5'($urandom)});
        send_byte(8'($urandom_range(1, 255)));
      end else if (pick < 97) begin
        send_byte(8'($urandom));
      end else begin
        send_byte($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hbf))
                                    : 8'($urandom_range(8'hf0, 8'hff)));
      end
    end
    wait_drained();
  endtask

  task automatic test_random_text();
    logic [utd_pkg::LW_WIDTH-1:0] widths[6];
    widths = '{13'($urandom_range(1, 4096)), 13'd4096, 13'($urandom),
               13'd1, 13'h1fff, utd_pkg::LINE_WIDTH_RST};
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 24; recv_idle_pct = 71; end
        1: begin send_idle_pct = 71; recv_idle_pct = 24; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_line_width(widths[2 * phase]);
      send_random_text(305);
      write_line_width(widths[2 * phase + 1]);
      send_random_text(305);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 24;
    recv_idle_pct = 71;
    test_ascii_after_reset();
    test_cursor_saturation();
    test_multibyte();
    test_skipped_bytes();
    test_line_width_extremes();
    test_output_hold_off();
    test_random_text();
    wait_drained();
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
